// File: hdl/go_back_n_sender_window_top_defines.svh
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top_defines.svh
// Assertion macros used by the go-back-N sender window checker.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_TOP_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define GBN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("go-back-N sender window check failed");

// Concurrent assertion that is also checked while reset is asserted.
`define GBN_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("go-back-N sender window reset check failed");

`endif

// File: hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Widths, codes and defaults of the go-back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int CMD_W      = 2;
    localparam int SEQ_W      = 10;
    localparam int KIND_W     = 2;
    localparam int WINDOW_W   = 5;
    localparam int TOTAL_W    = 11;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_MAX_PACKETS = 1024;
    localparam int DEF_MAX_WINDOW  = 16;

    localparam logic [WINDOW_W-1:0]  RST_WINDOW_SIZE   = 5'd4;
    localparam logic [TOTAL_W-1:0]   RST_PKT_COUNT     = 11'd10;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS = 16'd2000;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE   = 2'd0,
        CFG_PKT_COUNT     = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } t_cfg_idx;

endpackage

// File: hdl/go_back_n_sender_window_top.sv
// A start beat first clears the whole ack map, then sends each sequence number that fits
// the window. An ack beat marks its packet, walks the base over acked packets and then
// sends the numbers that now fit. A tick counts the timer, or on timeout resends from the base.
// The ack map memory has one write and one read port. After reset the block clears the
// ack map before it accepts its first beat.
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Go-back-N ARQ sender window control with the ack map held in a memory.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_top #(
    parameter int MAX_PACKETS = gbn_pkg::DEF_MAX_PACKETS,
    parameter int MAX_WINDOW  = gbn_pkg::DEF_MAX_WINDOW
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Command channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [gbn_pkg::CMD_W-1:0]      i_command,
    input  logic [gbn_pkg::SEQ_W-1:0]      i_ack_number,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gbn_pkg::KIND_W-1:0]     o_kind,
    output logic [gbn_pkg::SEQ_W-1:0]      o_sequence_res,
    output logic                           o_last_of_run
);
    import gbn_pkg::*;

    // Address width of the ack map and width of the sequence counters. The counters must
    // hold the packet total itself, and at least the width of the packet count register.
    localparam int AW    = $clog2(MAX_PACKETS);
    localparam int CW_MP = $clog2(MAX_PACKETS + 1);
    localparam int CW    = (CW_MP > TOTAL_W) ? CW_MP : TOTAL_W;

    typedef enum logic [2:0] {
        S_CLEAR,    // sweep the ack map to zero, one entry per cycle
        S_IDLE,     // wait for a command beat
        S_ONE,      // deliver a single result (reject or all done)
        S_WALK,     // issue the ack map read at the window base
        S_WCHK,     // test the read entry and step the base past acked packets
        S_DONE,     // decide between end of transfer and window refill
        S_FILL      // send sequence numbers until the window is full
    } t_state;

    // Configuration registers.
    logic [WINDOW_W-1:0]  r_window_size;
    logic [TOTAL_W-1:0]   r_pkt_count;
    logic [TIMEOUT_W-1:0] r_timeout_ticks;

    // Control state and its next values.
    t_state               r_state,    n_state;
    t_state               r_clr_ret,  n_clr_ret;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [CW-1:0]        r_base,     n_base;
    logic [CW-1:0]        r_next,     n_next;
    logic [TIMEOUT_W-1:0] r_timer,    n_timer;
    logic                 r_active,   n_active;
    t_kind                r_pkind,    n_pkind;
    logic [SEQ_W-1:0]     r_pseq,     n_pseq;

    // Output register: holds one result beat until it is taken.
    logic                 r_out_valid, n_out_valid;
    t_kind                r_kind,      n_kind;
    logic [SEQ_W-1:0]     r_seq,       n_seq;
    logic                 r_last,      n_last;

    // Ack map memory.
    logic                 mem_ackmap [MAX_PACKETS];
    logic                 r_rdata;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 wr_data;

    // Effective register values: window clamped to 1..MAX_WINDOW, total to 1..MAX_PACKETS,
    // a timeout of zero acts as one tick.
    logic [CW-1:0]        win_c;
    logic [CW-1:0]        tot_c;
    logic [TIMEOUT_W-1:0] limit_c;
    logic [CW:0]          win_end;
    logic [CW:0]          next_inc;
    logic                 fill_go;
    logic                 fill_last;
    logic [CW-1:0]        ack_ext;
    logic [CW-1:0]        base_inc;
    logic [TIMEOUT_W-1:0] timer_inc;
    logic                 slot_free;
    logic                 in_acc;

    always_comb begin
        if (r_window_size == '0) begin
            win_c = CW'(1);
        end else if (CW'(r_window_size) > CW'(MAX_WINDOW)) begin
            win_c = CW'(MAX_WINDOW);
        end else begin
            win_c = CW'(r_window_size);
        end
        if (r_pkt_count == '0) begin
            tot_c = CW'(1);
        end else if (CW'(r_pkt_count) > CW'(MAX_PACKETS)) begin
            tot_c = CW'(MAX_PACKETS);
        end else begin
            tot_c = CW'(r_pkt_count);
        end
        limit_c = (r_timeout_ticks == '0) ? TIMEOUT_W'(1) : r_timeout_ticks;
    end

    // The window may send while next is below both base plus window and the total. The
    // number being sent is the last of its run when its successor fails that test.
    assign win_end   = {1'b0, r_base} + {1'b0, win_c};
    assign next_inc  = {1'b0, r_next} + (CW + 1)'(1);
    assign fill_go   = ({1'b0, r_next} < win_end) && (r_next < tot_c);
    assign fill_last = !((next_inc < win_end) && (next_inc < {1'b0, tot_c}));
    assign ack_ext   = CW'(i_ack_number);
    assign base_inc  = r_base + CW'(1);
    assign timer_inc = r_timer + TIMEOUT_W'(1);

    // A new result may be loaded when the output register is empty or is being emptied.
    assign slot_free = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_sequence_res = r_seq;
    assign o_last_of_run  = r_last;

    always_comb begin
        n_state     = r_state;
        n_clr_ret   = r_clr_ret;
        n_clr_addr  = r_clr_addr;
        n_base      = r_base;
        n_next      = r_next;
        n_timer     = r_timer;
        n_active    = r_active;
        n_pkind     = r_pkind;
        n_pseq      = r_pseq;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_seq       = r_seq;
        n_last      = r_last;
        rd_addr     = r_base[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_clr_addr;
        wr_data     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_PACKETS - 1)) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_ret;
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    case (t_cmd'(i_command))
                        CMD_START: begin
                            // Restart from scratch; the window is sent after the sweep.
                            n_base    = '0;
                            n_next    = '0;
                            n_timer   = '0;
                            n_active  = 1'b1;
                            n_clr_ret = S_FILL;
                            n_state   = S_CLEAR;
                        end
                        CMD_ACK: begin
                            if (!r_active || (ack_ext >= tot_c)) begin
                                n_pkind = KIND_REJECT;
                                n_pseq  = i_ack_number;
                                n_state = S_ONE;
                            end else begin
                                // Mark the packet; the walk reads the map from the next
                                // cycle on, so it always sees this write.
                                wr_en   = 1'b1;
                                wr_addr = ack_ext[AW-1:0];
                                wr_data = 1'b1;
                                n_timer = '0;
                                n_state = S_WALK;
                            end
                        end
                        CMD_TICK: begin
                            if (r_active) begin
                                if (timer_inc >= limit_c) begin
                                    n_timer = '0;
                                    n_next  = r_base;
                                    n_state = S_FILL;
                                end else begin
                                    n_timer = timer_inc;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = r_pkind;
                    n_seq       = r_pseq;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_WALK: begin
                if (r_base < tot_c) begin
                    rd_addr = r_base[AW-1:0];
                    n_state = S_WCHK;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_WCHK: begin
                // The entry at the base comes back this cycle; while it is set, step the
                // base and read the following entry right away.
                if (r_rdata) begin
                    n_base = base_inc;
                    if (base_inc < tot_c) begin
                        rd_addr = base_inc[AW-1:0];
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (r_base >= tot_c) begin
                    n_active = 1'b0;
                    n_pkind  = KIND_DONE;
                    n_pseq   = '0;
                    n_state  = S_ONE;
                end else begin
                    n_state  = S_FILL;
                end
            end

            S_FILL: begin
                if (!fill_go) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_SEND;
                    n_seq       = r_next[SEQ_W-1:0];
                    n_last      = fill_last;
                    n_next      = next_inc[CW-1:0];
                    if (fill_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_ret       <= S_IDLE;
            r_clr_addr      <= '0;
            r_base          <= '0;
            r_next          <= '0;
            r_timer         <= '0;
            r_active        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_window_size   <= RST_WINDOW_SIZE;
            r_pkt_count     <= RST_PKT_COUNT;
            r_timeout_ticks <= RST_TIMEOUT_TICKS;
        end else begin
            r_state     <= n_state;
            r_clr_ret   <= n_clr_ret;
            r_clr_addr  <= n_clr_addr;
            r_base      <= n_base;
            r_next      <= n_next;
            r_timer     <= n_timer;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[WINDOW_W-1:0];
                    CFG_PKT_COUNT:     r_pkt_count     <= i_cfg_data[TOTAL_W-1:0];
                    CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[TIMEOUT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        // Payload registers carry no reset.
        r_pkind <= n_pkind;
        r_pseq  <= n_pseq;
        r_kind  <= n_kind;
        r_seq   <= n_seq;
        r_last  <= n_last;
    end

    // Ack map: one write port, one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_ackmap[wr_addr] <= wr_data;
        end
        r_rdata <= mem_ackmap[rd_addr];
    end

endmodule

// File: hdl/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the go-back-N sender window, bound to its top level.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_window_top_defines.svh"

module gbn_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [gbn_pkg::CMD_W-1:0]     i_command,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [gbn_pkg::KIND_W-1:0]    o_kind,
    input logic [gbn_pkg::SEQ_W-1:0]     o_sequence_res,
    input logic                          o_last_of_run
);
    import gbn_pkg::*;

    // No result beat is shown in the cycle after reset.
    `GBN_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // A stalled result beat holds its payload.
    `GBN_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_sequence_res) && $stable(o_last_of_run))

    // The all-done beat is a run of its own with sequence zero.
    `GBN_ASSERT(a_done_form, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_DONE) |-> o_last_of_run && (o_sequence_res == '0))

    // A rejected ack is always a single-beat run.
    `GBN_ASSERT(a_reject_last, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_REJECT) |-> o_last_of_run)

    // A start beat sweeps the ack map, so no command is taken right after it.
    `GBN_ASSERT(a_start_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_command == CMD_START) |=> !o_in_ready)

endmodule

bind go_back_n_sender_window_top gbn_checker u_gbn_checker (.*);

// File: tb/go_back_n_sender_window_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top_tb
// Self-checking bench for the go-back-N sender window. A clocked driver feeds
// command beats from a backlog in random bursts, and the result port stalls on
// a rotating pattern. Every accepted command runs through a local model of the
// window, whose predicted results are compared field by field with each result
// beat. A directed opening covers idle acks and ticks, the unused command,
// restarts, duplicates, out-of-range acks, register extremes and a total that
// shrinks under the base. Random transfers under random settings follow.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_top_tb;

    import gbn_pkg::*;

    // The command encoding that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // An ack may walk the base over the whole map without a result, so a pause
    // longer than one full walk is taken before any register write.
    localparam int SETTLE_CYCLES = 1100;
    // Longest quiet stretch of a correct run: the map clear after a start, a
    // settle pause, the register writes and a long result stall, several times.
    localparam int QUIET_LIMIT   = 12000;
    // Command beats sent over the whole run, directed ones included.
    localparam int ITEM_TARGET   = 260;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEQ_W-1:0] ack;
    } t_cmd_beat;

    typedef struct packed {
        t_kind            kind;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } t_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command      = '0;
    logic [SEQ_W-1:0]      i_ack_number   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic [SEQ_W-1:0]      o_sequence_res;
    logic                  o_last_of_run;

    go_back_n_sender_window_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_ack_number   (i_ack_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_sequence_res (o_sequence_res),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Window model: a copy of the registers as written and of the sender state.
    // ------------------------------------------------------------------------
    logic [WINDOW_W-1:0]  win_cfg     = RST_WINDOW_SIZE;
    logic [TOTAL_W-1:0]   total_cfg   = RST_PKT_COUNT;
    logic [TIMEOUT_W-1:0] timeout_cfg = RST_TIMEOUT_TICKS;

    logic [TOTAL_W-1:0]   win_base    = '0;
    logic [TOTAL_W-1:0]   win_next    = '0;
    logic                 acked_seq [DEF_MAX_PACKETS];
    logic [TIMEOUT_W-1:0] tick_count  = '0;
    logic                 xfer_open   = 1'b0;

    t_result   window_results[$];
    t_cmd_beat cmd_backlog[$];

    int unsigned stim_count   = 0;
    int unsigned beats_issued = 0;
    int unsigned beats_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        foreach (acked_seq[i]) acked_seq[i] = 1'b0;
    end

    // The total is used clamped to the map size, and zero counts as one.
    function automatic int span_total();
        if (total_cfg == '0) return 1;
        if (total_cfg > DEF_MAX_PACKETS) return DEF_MAX_PACKETS;
        return int'(total_cfg);
    endfunction

    // Sends every number that fits in the window and below the total.
    function automatic void refill();
        int win;
        int tot;
        win = (win_cfg == '0) ? 1 : ((win_cfg > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : int'(win_cfg));
        tot = span_total();
        while (win_next < win_base + win && win_next < tot) begin
            window_results.push_back('{kind: KIND_SEND, seq: win_next[SEQ_W-1:0], last: 1'b0});
            win_next++;
        end
    endfunction

    // Applies one accepted command to the model and queues what it causes.
    function automatic void advance_window(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] ack);
        int                   tot;
        int                   depth0;
        logic [TIMEOUT_W-1:0] lim;
        t_result              tail;
        tot    = span_total();
        depth0 = window_results.size();
        case (cmd)
            CMD_START: begin
                foreach (acked_seq[i]) acked_seq[i] = 1'b0;
                win_base   = '0;
                win_next   = '0;
                tick_count = '0;
                xfer_open  = 1'b1;
                refill();
            end
            CMD_ACK: begin
                if (!xfer_open || ack >= tot) begin
                    window_results.push_back('{kind: KIND_REJECT, seq: ack, last: 1'b0});
                end else begin
                    acked_seq[ack] = 1'b1;
                    while (win_base < tot && acked_seq[win_base]) win_base++;
                    tick_count = '0;
                    if (win_base >= tot) begin
                        xfer_open = 1'b0;
                        window_results.push_back('{kind: KIND_DONE, seq: '0, last: 1'b0});
                    end else begin
                        refill();
                    end
                end
            end
            CMD_TICK: begin
                if (xfer_open) begin
                    lim        = (timeout_cfg == '0) ? 16'd1 : timeout_cfg;
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= lim) begin
                        // Timeout: go back to the base and resend the window.
                        tick_count = '0;
                        win_next   = win_base;
                        refill();
                    end
                end
            end
            default: ;
        endcase
        if (window_results.size() > depth0) begin
            tail      = window_results.pop_back();
            tail.last = 1'b1;
            window_results.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. Beats go out in bursts of random length; between bursts
    // valid drops for a random gap, which is sometimes zero so that long runs
    // of back-to-back beats occur too. A presented beat holds until accepted.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_cmd_beat nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_window(i_command, i_ack_number);
                beats_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 || cmd_backlog.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    nxt = cmd_backlog.pop_front();
                    beats_issued++;
                    i_in_valid   <= 1'b1;
                    i_command    <= nxt.cmd;
                    i_ack_number <= nxt.ack;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result port back-pressure. Ready follows a 16-bit pattern that rotates
    // every cycle; the pattern is redrawn now and then as fully open, random,
    // mostly stalled or mostly open.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pat = '1;
    int          stall_age = 0;

    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pat = '1;
                1:       stall_pat = 16'($urandom());
                2:       stall_pat = 16'($urandom() & $urandom());
                default: stall_pat = 16'($urandom() | $urandom());
            endcase
            stall_age = $urandom_range(16, 96);
        end else begin
            stall_age--;
        end
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        i_out_ready <= stall_pat[0];
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each accepted result beat is checked against the oldest
    // prediction, and every differing field is reported.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (window_results.size() == 0) begin
                mismatches++;
                $error("result beat with none predicted: kind %0d sequence_res %0d",
                       o_kind, o_sequence_res);
            end else begin
                want = window_results.pop_front();
                if (o_kind !== want.kind) begin
                    mismatches++;
                    $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                end
                if (o_sequence_res !== want.seq) begin
                    mismatches++;
                    $error("sequence_res: expected %0d, actual %0d",
                           want.seq, o_sequence_res);
                end
                if (o_last_of_run !== want.last) begin
                    mismatches++;
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last, o_last_of_run);
                end
            end
        end
    end

    // Counts cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("go_back_n_sender_window_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_beat(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] ack);
        cmd_backlog.push_back('{cmd: cmd, ack: ack});
        stim_count++;
    endtask

    // Waits until every queued beat is accepted and every predicted result has
    // arrived, then lets a tick or a silent ack finish inside the block.
    task automatic drain();
        while (cmd_backlog.size() != 0 || beats_issued != beats_taken ||
               window_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_WINDOW_SIZE:   win_cfg     = val[WINDOW_W-1:0];
            CFG_PKT_COUNT:     total_cfg   = val[TOTAL_W-1:0];
            CFG_TIMEOUT_TICKS: timeout_cfg = val[TIMEOUT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random phase: mostly in-order acks of live transfers, mixed with
    // acks ahead of the base, duplicates, ticks, restarts and stray beats.
    // The phase stops early once the run has sent its share of beats.
    task automatic queue_random_phase(int unsigned tot);
        int unsigned k;
        int unsigned n;
        int unsigned r;
        int unsigned a;
        n = $urandom_range(20, 45);
        k = 0;
        push_beat(CMD_START, SEQ_W'($urandom_range(0, 1023)));
        repeat (n) begin
            if (stim_count >= ITEM_TARGET) break;
            r = $urandom_range(0, 99);
            if (k >= tot) begin
                // The transfer is complete; usually open the next one.
                if (r < 70) begin
                    push_beat(CMD_START, SEQ_W'($urandom_range(0, 1023)));
                    k = 0;
                end else if (r < 85) begin
                    push_beat(CMD_ACK, SEQ_W'($urandom_range(0, 1023)));
                end else begin
                    push_beat(CMD_TICK, SEQ_W'($urandom_range(0, 1023)));
                end
            end else if (r < 55) begin
                push_beat(CMD_ACK, SEQ_W'(k));
                k++;
            end else if (r < 65) begin
                a = k + $urandom_range(1, 4);
                push_beat(CMD_ACK, SEQ_W'((a < tot) ? a : k));
            end else if (r < 77) begin
                repeat ($urandom_range(1, 4))
                    push_beat(CMD_TICK, SEQ_W'($urandom_range(0, 1023)));
            end else if (r < 82) begin
                push_beat(CMD_ACK, SEQ_W'($urandom_range(0, k)));
            end else if (r < 88) begin
                push_beat(CMD_ACK, SEQ_W'($urandom_range(0, 1023)));
            end else if (r < 91) begin
                push_beat(CMD_UNUSED, SEQ_W'($urandom_range(0, 1023)));
            end else if (r < 94) begin
                push_beat(CMD_START, SEQ_W'($urandom_range(0, 1023)));
                k = 0;
            end else begin
                push_beat(CMD_ACK, SEQ_W'((tot < 1024) ? $urandom_range(tot, 1023)
                                                       : $urandom_range(0, 1023)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned win_v;
        int unsigned tot_v;
        int unsigned tmo_v;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: window 4, total 10. Idle ack, idle tick and the
        // unused command come first, then a transfer with an out-of-range
        // ack, a gap in the acks, a duplicate and a restart while active.
        push_beat(CMD_ACK, 10'd5);
        push_beat(CMD_TICK, 10'd1023);
        push_beat(CMD_UNUSED, 10'd682);
        push_beat(CMD_START, 10'd341);
        push_beat(CMD_ACK, 10'd1023);
        push_beat(CMD_ACK, 10'd0);
        push_beat(CMD_ACK, 10'd2);
        push_beat(CMD_ACK, 10'd0);
        push_beat(CMD_ACK, 10'd1);
        push_beat(CMD_START, 10'd0);
        drain();

        // Largest window, total above the map size, timeout zero acting as one.
        set_reg(CFG_WINDOW_SIZE, 16'd16);
        set_reg(CFG_PKT_COUNT, 16'd2047);
        set_reg(CFG_TIMEOUT_TICKS, 16'd0);
        push_beat(CMD_START, 10'd0);
        push_beat(CMD_TICK, 10'd0);
        push_beat(CMD_ACK, 10'd1023);
        push_beat(CMD_ACK, 10'd0);
        drain();

        // Window zero used as one, a one-packet transfer, timeout after two ticks.
        set_reg(CFG_WINDOW_SIZE, 16'd0);
        set_reg(CFG_PKT_COUNT, 16'd1);
        set_reg(CFG_TIMEOUT_TICKS, 16'd2);
        push_beat(CMD_START, 10'd0);
        push_beat(CMD_TICK, 10'd0);
        push_beat(CMD_TICK, 10'd0);
        push_beat(CMD_ACK, 10'd0);
        push_beat(CMD_ACK, 10'd0);
        drain();

        // Window above the limit; then the total shrinks below the base, so a
        // timeout resends nothing and the next good ack ends the transfer.
        set_reg(CFG_WINDOW_SIZE, 16'd31);
        set_reg(CFG_PKT_COUNT, 16'd20);
        set_reg(CFG_TIMEOUT_TICKS, 16'd1);
        push_beat(CMD_START, 10'd0);
        for (int i = 0; i < 5; i++) push_beat(CMD_ACK, i[SEQ_W-1:0]);
        drain();
        set_reg(CFG_PKT_COUNT, 16'd3);
        push_beat(CMD_TICK, 10'd0);
        push_beat(CMD_ACK, 10'd1);
        push_beat(CMD_ACK, 10'd5);
        drain();

        // Random phases, each under freshly drawn settings.
        while (stim_count < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       win_v = 0;
                1:       win_v = 31;
                2:       win_v = $urandom_range(17, 30);
                default: win_v = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 9))
                0:       tot_v = ($urandom_range(0, 1) != 0) ? 1024 : 2047;
                1:       tot_v = $urandom_range(0, 1);
                default: tot_v = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 9))
                0:       tmo_v = 0;
                1:       tmo_v = 65535;
                2:       tmo_v = $urandom_range(100, 65534);
                default: tmo_v = $urandom_range(1, 6);
            endcase
            set_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(win_v));
            set_reg(CFG_PKT_COUNT, CFG_DATA_W'(tot_v));
            set_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(tmo_v));
            queue_random_phase((tot_v == 0) ? 1 : ((tot_v > 1024) ? 1024 : tot_v));
            drain();
        end

        if (mismatches == 0)
            $display("go_back_n_sender_window_top regression: pass");
        else
            $display("go_back_n_sender_window_top regression: fail");
        $finish;
    end

endmodule
